// File: design/merkle_inclusion_proof_verifier_assert.svh
// Assertion macros used by the verifier checker
`ifndef MERKLE_INCLUSION_PROOF_VERIFIER_ASSERT_SVH
`define MERKLE_INCLUSION_PROOF_VERIFIER_ASSERT_SVH

// Checked only while reset is released
`define MIPV_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included
`define MIPV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/mipv_pkg.sv
// Shared types, constants and message helpers of the Merkle proof verifier
package mipv_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = 2;

  typedef enum logic [1:0] {
    REQ_LEAF  = 2'd0,
    REQ_LEFT  = 2'd1,
    REQ_RIGHT = 2'd2,
    REQ_ROOT  = 2'd3
  } req_e;

  localparam logic [1:0] LastWord = 2'd3;

  // One queued beat, classified by the front end
  typedef struct packed {
    req_e        kind;
    logic [1:0]  word_index;
    logic        last;
    logic [63:0] digest_word;
  } item_t;

  typedef struct packed {
    logic start;
  } core_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_sts_t;

  localparam logic [255:0] InitH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Ten-byte ASCII node prefix, first byte in the top bits
  localparam logic [79:0] NodePrefix = 80'h6361726c3a6e6f64653a;

  // ASCII hex character of nibble k of a 256-bit digest
  function automatic logic [7:0] hex_char(logic [255:0] dig, logic [5:0] k, logic upper);
    logic [255:0] sh;
    logic [3:0]   nib;
    sh  = dig >> (9'd252 - {1'b0, k, 2'b00});
    nib = sh[3:0];
    if (nib < 4'd10) hex_char = 8'h30 + {4'h0, nib};
    else hex_char = (upper ? 8'h41 : 8'h61) + {4'h0, nib} - 8'd10;
  endfunction

  // Byte n of the padded 192-byte node message
  function automatic logic [7:0] msg_byte(logic [7:0] n, logic [255:0] left,
                                          logic [255:0] right, logic upper);
    logic [79:0] ps;
    logic [7:0]  off;
    ps  = NodePrefix << {n[3:0], 3'b000};
    off = 8'd0;
    if (n < 8'd10) msg_byte = ps[79:72];
    else if (n < 8'd74) begin
      off = n - 8'd10;
      msg_byte = hex_char(left, off[5:0], upper);
    end else if (n < 8'd138) begin
      off = n - 8'd74;
      msg_byte = hex_char(right, off[5:0], upper);
    end else if (n == 8'd138) msg_byte = 8'h80;
    else if (n == 8'd190) msg_byte = 8'h04;
    else if (n == 8'd191) msg_byte = 8'h50;
    else msg_byte = 8'h00;
  endfunction

  // Big-endian 32-bit message word at word index idx (0..47)
  function automatic logic [31:0] msg_word(logic [5:0] idx, logic [255:0] left,
                                           logic [255:0] right, logic upper);
    logic [7:0] base;
    base = {idx, 2'b00};
    msg_word = {msg_byte(base, left, right, upper),
                msg_byte(base + 8'd1, left, right, upper),
                msg_byte(base + 8'd2, left, right, upper),
                msg_byte(base + 8'd3, left, right, upper)};
  endfunction

endpackage

// File: design/mipv_front.sv
// Front end: accepts input beats, classifies them and queues them
module mipv_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      in_kind_i,
  input  logic [1:0]      in_index_i,
  input  logic [63:0]     in_word_i,
  output logic            q_valid_o,
  output mipv_pkg::item_t q_item_o,
  input  logic            q_pop_i
);
  import mipv_pkg::*;

  item_t          mem_q [QDepth];
  logic [QAw-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QAw:0]   cnt_q, cnt_d;
  logic           push;
  item_t          item_in;

  // Classify the incoming beat
  always_comb begin
    item_in.kind        = req_e'(in_kind_i);
    item_in.word_index  = in_index_i;
    item_in.last        = (in_index_i == LastWord);
    item_in.digest_word = in_word_i;
  end

  assign in_ready_o = (cnt_q != QDepth[QAw:0]);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = mem_q[rd_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = q_pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + {{QAw{1'b0}}, push} - {{QAw{1'b0}}, q_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= item_in;
    end
  end

endmodule

// File: design/mipv_core.sv
// SHA-256 engine: one round per cycle over the three blocks of a node message
module mipv_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mipv_pkg::core_ctl_t ctl_i,
  output mipv_pkg::core_sts_t sts_o,
  output logic [5:0]          msg_idx_o,
  input  logic [31:0]         msg_word_i,
  output logic [255:0]        digest_o
);
  import mipv_pkg::*;

  typedef enum logic [1:0] {
    C_IDLE,
    C_ROUND,
    C_FIN
  } cstate_e;

  cstate_e     state_q;
  logic [5:0]  rnd_q;
  logic [1:0]  blk_q;
  logic        done_q;
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [31:0] w_q [16];
  logic [31:0] w_new, s0, s1, t1, t2, ep0, ep1, ch, maj;
  logic [31:0] h_sum [8];

  function automatic logic [31:0] rotr(logic [31:0] x, int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  assign msg_idx_o = {blk_q, rnd_q[3:0]};
  assign sts_o.busy = (state_q != C_IDLE);
  assign sts_o.done = done_q;

  // Round datapath
  always_comb begin
    s0  = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1  = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    w_new = (rnd_q < 6'd16) ? msg_word_i : s1 + w_q[9] + s0 + w_q[0];
    ep1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
    ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1  = v_q[7] + ep1 + ch + RoundK[rnd_q] + w_new;
    ep0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
    maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2  = ep0 + maj;
    for (int i = 0; i < 8; i++) h_sum[i] = h_q[i] + v_q[i];
  end

  for (genvar g = 0; g < 8; g++) begin : g_dig
    assign digest_o[255-32*g -: 32] = h_q[g];
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      rnd_q   <= '0;
      blk_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        C_IDLE: begin
          if (ctl_i.start) begin
            rnd_q   <= '0;
            blk_q   <= '0;
            state_q <= C_ROUND;
          end
        end
        C_ROUND: begin
          rnd_q <= rnd_q + 6'd1;
          if (rnd_q == 6'd63) state_q <= C_FIN;
        end
        C_FIN: begin
          rnd_q <= '0;
          if (blk_q == 2'd2) begin
            done_q  <= 1'b1;
            state_q <= C_IDLE;
          end else begin
            blk_q   <= blk_q + 2'd1;
            state_q <= C_ROUND;
          end
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  // Working variables, chaining value and schedule line
  always_ff @(posedge clk_i) begin
    if (state_q == C_IDLE && ctl_i.start) begin
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= InitH[255-32*i -: 32];
        v_q[i] <= InitH[255-32*i -: 32];
      end
    end else if (state_q == C_ROUND) begin
      v_q[0] <= t1 + t2;
      v_q[1] <= v_q[0];
      v_q[2] <= v_q[1];
      v_q[3] <= v_q[2];
      v_q[4] <= v_q[3] + t1;
      v_q[5] <= v_q[4];
      v_q[6] <= v_q[5];
      v_q[7] <= v_q[6];
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= w_new;
    end else if (state_q == C_FIN) begin
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= h_sum[i];
        v_q[i] <= h_sum[i];
      end
    end
  end

endmodule

// File: design/mipv_back.sv
// Back end: digest registers, step handling, root compare and result register
module mipv_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            hex_upper_i,
  input  logic            q_valid_i,
  input  mipv_pkg::item_t q_item_i,
  output logic            q_pop_o,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output logic            res_match_o,
  output logic [7:0]      res_steps_o
);
  import mipv_pkg::*;

  typedef enum logic {
    B_IDLE,
    B_HASH
  } bstate_e;

  bstate_e      state_q;
  logic [63:0]  cur_q [4];
  logic [63:0]  sib_q [4];
  logic         mis_q;
  logic [7:0]   step_q;
  logic         left_sib_q;
  logic         res_valid_q;
  logic         res_match_q;
  logic [7:0]   res_steps_q;
  logic         mis_new;
  logic         is_root_last;
  logic [255:0] cur_flat, sib_flat, left, right, digest;
  logic [5:0]   msg_idx;
  logic [31:0]  msg_word;
  core_ctl_t    core_ctl;
  core_sts_t    core_sts;

  assign cur_flat = {cur_q[0], cur_q[1], cur_q[2], cur_q[3]};
  assign sib_flat = {sib_q[0], sib_q[1], sib_q[2], sib_q[3]};
  assign left     = left_sib_q ? sib_flat : cur_flat;
  assign right    = left_sib_q ? cur_flat : sib_flat;
  assign msg_word = mipv_pkg::msg_word(msg_idx, left, right, hex_upper_i);

  // Take a beat when idle; a final root beat also needs the result slot
  assign is_root_last = (q_item_i.kind == REQ_ROOT) && q_item_i.last;
  assign q_pop_o = (state_q == B_IDLE) && !core_sts.busy && q_valid_i &&
                   (!is_root_last || !res_valid_q || res_ready_i);
  assign core_ctl.start = q_pop_o && q_item_i.last &&
                          (q_item_i.kind == REQ_LEFT || q_item_i.kind == REQ_RIGHT);

  assign mis_new = ((q_item_i.word_index == 2'd0) ? 1'b0 : mis_q) ||
                   (q_item_i.digest_word != cur_q[q_item_i.word_index]);

  mipv_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (core_ctl),
    .sts_o      (core_sts),
    .msg_idx_o  (msg_idx),
    .msg_word_i (msg_word),
    .digest_o   (digest)
  );

  assign res_valid_o = res_valid_q;
  assign res_match_o = res_match_q;
  assign res_steps_o = res_steps_q;

  // Sequencer and digest state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      mis_q       <= 1'b0;
      step_q      <= '0;
      left_sib_q  <= 1'b0;
      res_valid_q <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        cur_q[i] <= '0;
        sib_q[i] <= '0;
      end
    end else begin
      // Result slot frees unless a new root verdict refills it this cycle
      if (res_valid_q && res_ready_i && !(q_pop_o && is_root_last)) res_valid_q <= 1'b0;
      case (state_q)
        B_IDLE: begin
          if (q_pop_o) begin
            case (q_item_i.kind)
              REQ_LEAF: begin
                cur_q[q_item_i.word_index] <= q_item_i.digest_word;
                if (q_item_i.last) step_q <= '0;
              end
              REQ_LEFT, REQ_RIGHT: begin
                sib_q[q_item_i.word_index] <= q_item_i.digest_word;
                left_sib_q <= (q_item_i.kind == REQ_LEFT);
                if (q_item_i.last) state_q <= B_HASH;
              end
              REQ_ROOT: begin
                mis_q <= mis_new;
                if (q_item_i.last) res_valid_q <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        B_HASH: begin
          if (core_sts.done) begin
            for (int i = 0; i < 4; i++) cur_q[i] <= digest[255-64*i -: 64];
            if (step_q != 8'hff) step_q <= step_q + 8'd1;
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (q_pop_o && is_root_last) begin
      res_match_q <= !mis_new;
      res_steps_q <= step_q;
    end
  end

endmodule

// File: design/merkle_inclusion_proof_verifier.sv
// Top level of the Merkle inclusion proof verifier
//
// Input stream: each beat carries one 64-bit quarter of a digest. tuser says
// whether it is a leaf, a left sibling, a right sibling or the expected root
// word; tdata holds the quarter index and the word. Word index 3 completes
// a digest. A completed sibling starts a SHA-256 over the 138-byte node
// text (prefix and hex of left then right digest, letter case from the
// configuration register).
// Output stream: one beat per completed root, with the match flag and the
// saturating count of proof steps hashed since the leaf.
// Timing: beats enter a four-entry queue. A plain word at the queue head is
// consumed in that same cycle once the back end is idle; a completing
// sibling word occupies the back end while the one-round-per-cycle hash
// unit runs three blocks of rounds with feed-forward, start and write-back.
// A root result appears in the cycle after its last word is taken.
// Reset clears the digests, count and queue; hex case resets to lowercase.
// A stalled result holds in its register; the back end then takes no further
// final root word, while the queue keeps accepting until full.
module merkle_inclusion_proof_verifier (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,      // hex_upper
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,  // [1:0] word_index, [65:2] digest_word, rest zero
  input  logic [1:0]  s_axis_tuser_i,  // [1:0] req_type
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o   // [0] match, [8:1] steps_applied, rest zero
);
  import mipv_pkg::*;

  logic       hex_upper_q;
  logic       q_valid, q_pop;
  item_t      q_item;
  logic       res_match;
  logic [7:0] res_steps;

  assign cfg_ready_o = 1'b1;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) hex_upper_q <= 1'b0;
    else if (cfg_valid_i) hex_upper_q <= cfg_data_i;
  end

  mipv_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_kind_i  (s_axis_tuser_i),
    .in_index_i (s_axis_tdata_i[1:0]),
    .in_word_i  (s_axis_tdata_i[65:2]),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  mipv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hex_upper_i (hex_upper_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_match_o (res_match),
    .res_steps_o (res_steps)
  );

  assign m_axis_tdata_o = {7'd0, res_steps, res_match};

endmodule

// File: design/mipv_checker.sv
// Port-level checker for the verifier, bound to the top level
`include "merkle_inclusion_proof_verifier_assert.svh"

module mipv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o
);

  // A stalled result beat stays offered
  `MIPV_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o, "result beat dropped while stalled")

  // No result beat while reset is asserted
  `MIPV_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |-> !m_axis_tvalid_o, "result beat during reset")

  // Result padding bits stay zero on every offered beat
  `MIPV_ASSERT(a_pad_zero, clk_i, rst_ni, m_axis_tvalid_o |-> m_axis_tdata_o[15:9] == 7'd0, "nonzero result padding")

  // A stalled result keeps its payload
  `MIPV_ASSERT(a_out_stable, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o), "result payload changed while stalled")

endmodule

bind merkle_inclusion_proof_verifier mipv_checker u_mipv_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// File: verif/merkle_inclusion_proof_verifier_tb.sv
// Self-checking testbench of the Merkle inclusion proof verifier
module merkle_inclusion_proof_verifier_tb;
  import mipv_pkg::*;

  // Predicts the root verdicts from accepted beats and checks returned results
  class proof_scoreboard;
    bit         hex_upper;
    bit [255:0] cur_digest;
    bit [255:0] sib_digest;
    bit         root_bad;
    bit [7:0]   step_cnt;
    bit [8:0]   verdict_q[$];   // {steps, match}
    int         errors;
    int         checked;

    function bit [31:0] rotr(bit [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function bit [7:0] hex_text(bit [3:0] nib);
      if (nib < 4'd10) return 8'h30 + nib;
      return (hex_upper ? 8'h41 : 8'h61) + nib - 8'd10;
    endfunction

    // SHA-256 over prefix, hex of left, hex of right
    function bit [255:0] node_hash(bit [255:0] lhs, bit [255:0] rhs);
      bit [79:0]  pfx;
      bit [7:0]   msg[192];
      bit [31:0]  hs[8];
      bit [31:0]  w[64];
      bit [31:0]  va, vb, vc, vd, ve, vf, vg, vh, t1, t2, s0, s1;
      bit [255:0] res;
      pfx = 80'h6361726c3a6e6f64653a;
      foreach (msg[i]) msg[i] = 8'h00;
      for (int i = 0; i < 10; i++) msg[i] = pfx[79 - 8*i -: 8];
      for (int j = 0; j < 64; j++) begin
        msg[10 + j] = hex_text(lhs[255 - 4*j -: 4]);
        msg[74 + j] = hex_text(rhs[255 - 4*j -: 4]);
      end
      msg[138] = 8'h80;
      msg[190] = 8'h04;
      msg[191] = 8'h50;
      for (int i = 0; i < 8; i++) hs[i] = InitH[255 - 32*i -: 32];
      for (int b = 0; b < 3; b++) begin
        for (int t = 0; t < 16; t++)
          w[t] = {msg[64*b + 4*t], msg[64*b + 4*t + 1], msg[64*b + 4*t + 2],
                  msg[64*b + 4*t + 3]};
        for (int t = 16; t < 64; t++) begin
          s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
          s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
          w[t] = s1 + w[t-7] + s0 + w[t-16];
        end
        {va, vb, vc, vd, ve, vf, vg, vh} = {hs[0], hs[1], hs[2], hs[3],
                                            hs[4], hs[5], hs[6], hs[7]};
        for (int t = 0; t < 64; t++) begin
          t1 = vh + (rotr(ve, 6) ^ rotr(ve, 11) ^ rotr(ve, 25)) + ((ve & vf) ^ (~ve & vg))
               + RoundK[t] + w[t];
          t2 = (rotr(va, 2) ^ rotr(va, 13) ^ rotr(va, 22)) + ((va & vb) ^ (va & vc) ^ (vb & vc));
          vh = vg; vg = vf; vf = ve; ve = vd + t1;
          vd = vc; vc = vb; vb = va; va = t1 + t2;
        end
        hs[0] += va; hs[1] += vb; hs[2] += vc; hs[3] += vd;
        hs[4] += ve; hs[5] += vf; hs[6] += vg; hs[7] += vh;
      end
      res = {hs[0], hs[1], hs[2], hs[3], hs[4], hs[5], hs[6], hs[7]};
      return res;
    endfunction

    function void note_input(req_e kind, bit [1:0] idx, bit [63:0] word);
      bit [8:0] vd;
      case (kind)
        REQ_LEAF: begin
          cur_digest[255 - 64*idx -: 64] = word;
          if (idx == LastWord) step_cnt = 0;
        end
        REQ_LEFT, REQ_RIGHT: begin
          sib_digest[255 - 64*idx -: 64] = word;
          if (idx == LastWord) begin
            if (kind == REQ_LEFT) cur_digest = node_hash(sib_digest, cur_digest);
            else cur_digest = node_hash(cur_digest, sib_digest);
            if (step_cnt != 8'd255) step_cnt++;
          end
        end
        default: begin
          if (idx == 2'd0) root_bad = 0;
          if (word != cur_digest[255 - 64*idx -: 64]) root_bad = 1;
          if (idx == LastWord) begin
            vd = {step_cnt, ~root_bad};
            verdict_q = {verdict_q, vd};
          end
        end
      endcase
    endfunction

    function void check_result(bit [15:0] data);
      bit [8:0] exp_v;
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result beat, actual match=%0d steps=%0d",
                 $time, data[0], data[8:1]);
        errors++;
        return;
      end
      exp_v = verdict_q.pop_front();
      checked++;
      if (data[0] != exp_v[0]) begin
        $display("%0t: match expected %0d actual %0d", $time, exp_v[0], data[0]);
        errors++;
      end
      if (data[8:1] != exp_v[8:1]) begin
        $display("%0t: steps_applied expected %0d actual %0d", $time, exp_v[8:1], data[8:1]);
        errors++;
      end
    endfunction
  endclass

  typedef struct {
    req_e      kind;
    bit [1:0]  idx;
    bit [63:0] word;
  } beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_data_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [71:0] s_axis_tdata_i;   // [1:0] word_index, [65:2] digest_word
  logic [1:0]  s_axis_tuser_i;   // [1:0] req_type
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [15:0] m_axis_tdata_o;   // [0] match, [8:1] steps_applied

  proof_scoreboard sb;
  proof_scoreboard planner;     // runs ahead of the block while stimulus is built
  beat_t           beat_list[$];
  int              idle_pct;
  int              stall_pct;
  int              hold_left;
  int              beats_in;

  merkle_inclusion_proof_verifier u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #40000000;
    $display("Mismatches found");
    $finish;
  end

  // Result side: random stalls plus one long hold-off
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        m_axis_tready_i = 1'b0;
        hold_left--;
      end else begin
        m_axis_tready_i = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Beat monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        sb.note_input(req_e'(s_axis_tuser_i), s_axis_tdata_i[1:0], s_axis_tdata_i[65:2]);
        beats_in++;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o);
    end
  end

  task automatic add_beat(req_e kind, bit [1:0] idx, bit [63:0] word);
    beat_t bt;
    bt.kind = kind;
    bt.idx  = idx;
    bt.word = word;
    beat_list = {beat_list, bt};
    planner.note_input(kind, idx, word);
  endtask

  task automatic add_digest(req_e kind, bit [255:0] dig);
    for (int i = 0; i < 4; i++) add_beat(kind, i[1:0], dig[255 - 64*i -: 64]);
  endtask

  function automatic bit [255:0] rand_digest();
    bit [255:0] d;
    for (int i = 0; i < 8; i++) d[32*i +: 32] = $urandom();
    return d;
  endfunction

  // Leaf, proof steps with random sides, then a root that is right or corrupted
  task automatic add_proof(int n_steps, bit good_root);
    bit [255:0] rt;
    add_digest(REQ_LEAF, rand_digest());
    for (int s = 0; s < n_steps; s++)
      add_digest($urandom_range(1) ? REQ_LEFT : REQ_RIGHT, rand_digest());
    rt = planner.cur_digest;
    if (!good_root) rt[$urandom_range(255)] ^= 1'b1;
    add_digest(REQ_ROOT, rt);
  endtask

  task automatic gen_batch(int n_beats);
    int pick;
    while (beat_list.size() < n_beats) begin
      pick = $urandom_range(99);
      if (pick < 78) add_proof($urandom_range(3), $urandom_range(9) < 7);
      else if (pick < 90)
        add_beat(req_e'(2'($urandom_range(3))), 2'($urandom_range(3)),
                 {$urandom(), $urandom()});
      else begin
        // broken sequence: partial leaf then a root tail
        add_beat(REQ_LEAF, 2'($urandom_range(2)), {$urandom(), $urandom()});
        add_beat(REQ_ROOT, 2'd2, {$urandom(), $urandom()});
        add_beat(REQ_ROOT, LastWord, planner.cur_digest[63:0]);
      end
    end
  endtask

  task automatic send_beat(beat_t bt);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i  = bt.kind;
    s_axis_tdata_i  = {6'd0, bt.word, bt.idx};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drive_list();
    while (beat_list.size() > 0) send_beat(beat_list.pop_front());
    s_axis_tvalid_i = 1'b0;
  endtask

  // Wait for every result, then for any hash still running
  task automatic drain();
    while (sb.verdict_q.size() != 0) @(posedge clk_i);
    repeat (1200) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_case(bit upper);
    cfg_valid_i = 1'b1;
    cfg_data_i  = upper;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i  = 1'b0;
    sb.hex_upper      = upper;
    planner.hex_upper = upper;
  endtask

  initial begin
    sb              = new();
    planner         = new();
    idle_pct        = 0;
    stall_pct       = 0;
    hold_left       = 0;
    beats_in        = 0;
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = REQ_LEAF;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extreme words, both sides, good and bad roots, out-of-order words
    add_digest(REQ_LEAF, {256{1'b1}});
    add_digest(REQ_LEFT, '0);
    add_digest(REQ_RIGHT, {256{1'b1}});
    add_digest(REQ_ROOT, planner.cur_digest);
    add_digest(REQ_ROOT, planner.cur_digest ^ 256'd1);
    add_beat(REQ_LEAF, LastWord, 64'h0);
    add_beat(REQ_LEAF, 2'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    add_beat(REQ_ROOT, LastWord, 64'h0);
    drive_list();

    // Phase: no idling, lowercase
    gen_batch(120);
    drive_list();
    drain();
    write_case(1'b1);

    // Phase: idle sender, uppercase
    idle_pct = 73;
    gen_batch(120);
    drive_list();
    drain();
    write_case(1'b0);

    // Phase: stalling receiver with one long hold-off
    idle_pct  = 0;
    stall_pct = 73;
    hold_left = 2000;
    for (int i = 0; i < 6; i++) add_proof(0, 1'b1);
    gen_batch(130);
    drive_list();
    drain();
    write_case(1'b1);

    // Phase: both idle, long proof past step saturation
    idle_pct  = 13;
    stall_pct = 13;
    add_proof(257, 1'b1);
    gen_batch(1160);
    drive_list();
    drain();

    $display("Run covered %0d input beats and %0d root verdicts,", beats_in, sb.checked);
    $display("both hex cases, four idle patterns, a long stall and step saturation.");
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/mipv_pkg.sv
design/mipv_front.sv
design/mipv_core.sv
design/mipv_back.sv
design/merkle_inclusion_proof_verifier.sv
design/mipv_checker.sv
verif/merkle_inclusion_proof_verifier_tb.sv
